@@ hdl/mcra_pkg.sv @@
// Shared types, constants and helper functions of the MCRA noise suppressor.
package mcra_pkg;

  // Default bin memory depth
  localparam int unsigned MaxBinsDef = 1024;

  // Datapath widths
  localparam int unsigned SmpW     = 24;
  localparam int unsigned PwrW     = 48;
  localparam int unsigned OutW     = 32;
  localparam int unsigned RootW    = 24;
  localparam int unsigned MulAW    = 48;
  localparam int unsigned MulBW    = 24;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned DivNW    = 64;
  localparam int unsigned DivDW    = 24;
  localparam int unsigned FrmCntW  = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [15:0] AlphaSRst   = 16'd62259;
  localparam logic [15:0] AlphaDRst   = 16'd62259;
  localparam logic [15:0] AlphaD2Rst  = 16'd63570;
  localparam logic [15:0] DeltaRst    = 16'd66;
  localparam logic [15:0] WindowRst   = 16'd75;
  localparam logic [11:0] OutAmpRst   = 12'd512;
  localparam logic        NoiseOnlyRst = 1'b0;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA_S    = 3'd0,
    CFG_ALPHA_D    = 3'd1,
    CFG_ALPHA_D2   = 3'd2,
    CFG_DELTA      = 3'd3,
    CFG_WINDOW     = 3'd4,
    CFG_OUT_AMP    = 3'd5,
    CFG_NOISE_ONLY = 3'd6
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE,
    ST_PC0, ST_PC1, ST_PC2,
    ST_P0, ST_P1, ST_P2,
    ST_SF, ST_SFW,
    ST_S0, ST_S1, ST_S2,
    ST_M, ST_N0, ST_N1, ST_N2,
    ST_D0, ST_D1, ST_DW,
    ST_L0, ST_L1, ST_L2,
    ST_WB, ST_QM, ST_QN,
    ST_AMP, ST_BIG,
    ST_XM, ST_XD, ST_XW,
    ST_YM, ST_YD, ST_YW,
    ST_PUT
  } state_e;

  // One word of the per-bin state memory
  typedef struct packed {
    logic [PwrW-1:0] s;
    logic [PwrW-1:0] smin;
    logic [PwrW-1:0] stmp;
    logic [PwrW-1:0] lam;
  } bin_state_t;

  // Magnitude of a signed sample
  function automatic logic [SmpW-1:0] abs_smp(input logic [SmpW-1:0] v);
    logic [SmpW-1:0] r;
    r = v[SmpW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  // Apply sign to a magnitude and saturate to 32 bits
  function automatic logic [OutW-1:0] sat_sm(input logic neg, input logic [DivNW-1:0] q);
    logic [OutW-1:0] r;
    if (!neg) begin
      r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[OutW-1:0];
    end else begin
      r = (q > 64'h8000_0000) ? 32'h8000_0000 : (~q[OutW-1:0] + 1'b1);
    end
    return r;
  endfunction

endpackage

@@ hdl/mcra_noise_suppressor_core.sv @@
// MCRA noise suppressor: per-bin noise tracking and spectral subtraction.
//
// Input channel (in_valid_i/in_ready_o) takes one FFT bin word per handshake,
// DC first, last_bin_i marking the end of a frame. Output channel
// (out_valid_o/out_ready_i) returns processed bins in order, trailing the
// input by one bin: DC leaves at once, as does bin 1 ending a frame, and a later
// last bin releases two words. Configuration is a plain write port (cfg_we_i,
// cfg_idx_i, cfg_data_i). One bin word is handled at a time. A word other than
// DC spends most of its time in the shared 64-step divider (two scalings plus
// the first-window noise average) and two 24-step square roots. A last bin
// beyond bin 1 takes two passes. Per-bin state lives in one single-port-style
// memory, read once and written back once per result.
// After reset all MAX_BINS words of the state memory are swept to zero with
// in_ready_o low; configuration writes are taken throughout.
// A finished word waits in the output register; a stalled receiver holds the
// sequencer only when the next word is ready to go out.
module mcra_noise_suppressor_core
  import mcra_pkg::*;
#(
  parameter int unsigned MAX_BINS = MaxBinsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [SmpW-1:0] bin_re_i,
  input  logic signed [SmpW-1:0] bin_im_i,
  input  logic                   last_bin_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] out_re_o,
  output logic signed [OutW-1:0] out_im_o,
  output logic                   last_of_frame_o
);

  localparam int unsigned AW = $clog2(MAX_BINS);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_BINS - 1);

  // configuration registers
  logic [15:0] alpha_s_q, alpha_d_q, alpha_d2_q, delta_q, window_q;
  logic [11:0] out_amp_q;
  logic        noise_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_s_q    <= AlphaSRst;
      alpha_d_q    <= AlphaDRst;
      alpha_d2_q   <= AlphaD2Rst;
      delta_q      <= DeltaRst;
      window_q     <= WindowRst;
      out_amp_q    <= OutAmpRst;
      noise_only_q <= NoiseOnlyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_S:    alpha_s_q    <= cfg_data_i;
        CFG_ALPHA_D:    alpha_d_q    <= cfg_data_i;
        CFG_ALPHA_D2:   alpha_d2_q   <= cfg_data_i;
        CFG_DELTA:      delta_q      <= cfg_data_i;
        CFG_WINDOW:     window_q     <= cfg_data_i;
        CFG_OUT_AMP:    out_amp_q    <= cfg_data_i[11:0];
        CFG_NOISE_ONLY: noise_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [16:0] one_m_as, one_m_ad;
  assign one_m_as = 17'd65536 - {1'b0, alpha_s_q};
  assign one_m_ad = 17'd65536 - {1'b0, alpha_d_q};

  // sequencer state and working registers
  state_e state_q, state_d;

  logic [AW-1:0]      clr_cnt_q, bin_pos_q, e_j_q;
  logic [SmpW-1:0]    pend_re_q, pend_im_q, cur_re_q, cur_im_q, e_re_q, e_im_q;
  logic [PwrW-1:0]    pend_pl_q, e_pl_q, e_pr_q, pacc_q, p_q, sf_q;
  logic [PwrW-1:0]    s_q, smin_q, stmp_q, lam_q;
  logic [63:0]        acc_q;
  logic [FrmCntW-1:0] fc_q;
  logic               fw_q, finit_q, frest_q;
  logic               e_last_q, second_q, upd_pend_q, cond_q;
  logic [RootW-1:0]   mag_q, nm_q;
  logic [27:0]        big_q;
  logic [OutW-1:0]    res_re_q, res_im_q;
  logic               out_valid_q, out_last_q;
  logic [OutW-1:0]    out_re_q, out_im_q;
  logic [ProdW-1:0]   prod_q;

  // state memory
  bin_state_t      state_mem [MAX_BINS];
  bin_state_t      rd_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  bin_state_t      mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) state_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= state_mem[e_j_q];
  end

  // shared multiplier, registered product
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // iterative square root, two radicand bits a step
  logic             sq_start, sq_busy_q;
  logic [PwrW-1:0]  sq_in, sq_x_q;
  logic [25:0]      sq_rem_q;
  logic [RootW-1:0] sq_root_q;
  logic [4:0]       sq_cnt_q;
  logic [27:0]      sq_sh, sq_trial;

  assign sq_sh    = {sq_rem_q, sq_x_q[PwrW-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (sq_start) begin
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= '0;
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q + 1'b1;
      if (sq_cnt_q == 5'(RootW - 1)) sq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_x_q    <= sq_in;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_busy_q) begin
      sq_x_q <= {sq_x_q[PwrW-3:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_q  <= 26'(sq_sh - sq_trial);
        sq_root_q <= {sq_root_q[RootW-2:0], 1'b1};
      end else begin
        sq_rem_q  <= sq_sh[25:0];
        sq_root_q <= {sq_root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // restoring divider, one quotient bit a step
  logic              dv_start, dv_busy_q;
  logic [DivNW-1:0]  dv_num, dv_q;
  logic [DivDW-1:0]  dv_den, dv_den_q, dv_rem_q;
  logic [5:0]        dv_cnt_q;
  logic [DivDW:0]    dv_sh;
  logic              dv_ge;

  assign dv_sh = {dv_rem_q, dv_q[DivNW-1]};
  assign dv_ge = dv_sh >= {1'b0, dv_den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_cnt_q  <= '0;
    end else if (dv_start) begin
      dv_busy_q <= 1'b1;
      dv_cnt_q  <= '0;
    end else if (dv_busy_q) begin
      dv_cnt_q <= dv_cnt_q + 1'b1;
      if (dv_cnt_q == 6'(DivNW - 1)) dv_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      dv_q     <= dv_num;
      dv_den_q <= dv_den;
      dv_rem_q <= '0;
    end else if (dv_busy_q) begin
      dv_q     <= {dv_q[DivNW-2:0], dv_ge};
      dv_rem_q <= dv_ge ? DivDW'(dv_sh - {1'b0, dv_den_q}) : dv_sh[DivDW-1:0];
    end
  end

  // handshake helpers
  logic in_fire, put_fire;
  logic pos_zero, pos_one, last_eff;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign put_fire   = (state_q == ST_PUT) && (!out_valid_q || out_ready_i);
  assign pos_zero   = (bin_pos_q == '0);
  assign pos_one    = (bin_pos_q == AW'(1));
  assign last_eff   = last_bin_i || (bin_pos_q >= LastAddr);

  // combinational values used in several states
  logic [49:0]      sf_sum;
  logic [65:0]      mac_sum;
  logic [PwrW-1:0]  smin_n, stmp_n;
  logic [RootW-1:0] m_sel;

  assign sf_sum  = {2'b00, e_pl_q} + {1'b0, p_q, 1'b0} + {2'b00, e_pr_q};
  assign mac_sum = {2'b00, acc_q} + prod_q[65:0] + 66'd32768;
  assign m_sel   = noise_only_q ? nm_q : ((mag_q > nm_q) ? (mag_q - nm_q) : '0);

  always_comb begin
    smin_n = rd_q.smin;
    stmp_n = rd_q.stmp;
    if (finit_q) begin
      smin_n = s_q;
      stmp_n = s_q;
    end
    if (frest_q) begin
      smin_n = (stmp_n < s_q) ? stmp_n : s_q;
      stmp_n = s_q;
    end else begin
      smin_n = (smin_n < s_q) ? smin_n : s_q;
      stmp_n = (stmp_n < s_q) ? stmp_n : s_q;
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  // next state, memory port, multiplier operands, unit starts
  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = e_j_q;
    mem_wdata = '{s: s_q, smin: smin_q, stmp: stmp_q, lam: lam_q};
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_in     = p_q;
    dv_start  = 1'b0;
    dv_num    = '0;
    dv_den    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        if (clr_cnt_q == LastAddr) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (pos_zero || (pos_one && last_eff)) state_d = ST_P0;
          else if (!pos_one)                     state_d = ST_PC0;
        end
      end
      ST_PC0: begin
        mul_a   = MulAW'(abs_smp(cur_re_q));
        mul_b   = abs_smp(cur_re_q);
        state_d = ST_PC1;
      end
      ST_PC1: begin
        mul_a   = MulAW'(abs_smp(cur_im_q));
        mul_b   = abs_smp(cur_im_q);
        state_d = ST_PC2;
      end
      ST_PC2: state_d = ST_P0;
      ST_P0: begin
        mem_re  = 1'b1;
        mul_a   = MulAW'(abs_smp(e_re_q));
        mul_b   = abs_smp(e_re_q);
        state_d = ST_P1;
      end
      ST_P1: begin
        mul_a   = MulAW'(abs_smp(e_im_q));
        mul_b   = abs_smp(e_im_q);
        state_d = ST_P2;
      end
      ST_P2: state_d = ST_SF;
      ST_SF: begin
        if (e_j_q == '0) begin
          sq_start = 1'b1;
          state_d  = ST_SFW;
        end else begin
          state_d = ST_S0;
        end
      end
      ST_SFW: if (!sq_busy_q) state_d = ST_S0;
      ST_S0: begin
        mul_a   = rd_q.s;
        mul_b   = MulBW'(alpha_s_q);
        state_d = ST_S1;
      end
      ST_S1: begin
        mul_a   = sf_q;
        mul_b   = MulBW'(one_m_as);
        state_d = ST_S2;
      end
      ST_S2: state_d = ST_M;
      ST_M:  state_d = ST_N0;
      ST_N0: begin
        mul_a   = smin_q;
        mul_b   = MulBW'(delta_q);
        state_d = ST_N1;
      end
      ST_N1: begin
        mul_a   = MulAW'(fc_q);
        mul_b   = MulBW'(alpha_d_q);
        state_d = ST_N2;
      end
      ST_N2: begin
        if (!cond_q) state_d = ST_WB;
        else if (fw_q && (prod_q < ProdW'(65536)) && (fc_q != '0)) state_d = ST_D0;
        else state_d = ST_L0;
      end
      ST_D0: begin
        mul_a   = p_q;
        mul_b   = MulBW'(fc_q - 1'b1);
        state_d = ST_D1;
      end
      ST_D1: begin
        dv_start = 1'b1;
        dv_num   = {16'd0, lam_q} + prod_q[63:0];
        dv_den   = DivDW'(fc_q);
        state_d  = ST_DW;
      end
      ST_DW: if (!dv_busy_q) state_d = ST_WB;
      ST_L0: begin
        mul_a   = lam_q;
        mul_b   = MulBW'(alpha_d2_q);
        state_d = ST_L1;
      end
      ST_L1: begin
        mul_a   = p_q;
        mul_b   = MulBW'(one_m_ad);
        state_d = ST_L2;
      end
      ST_L2: state_d = ST_WB;
      ST_WB: begin
        mem_we = 1'b1;
        if (e_j_q == '0) begin
          state_d = ST_PUT;
        end else begin
          sq_start = 1'b1;
          state_d  = ST_QM;
        end
      end
      ST_QM: begin
        if (!sq_busy_q) begin
          sq_start = 1'b1;
          sq_in    = lam_q;
          state_d  = ST_QN;
        end
      end
      ST_QN: if (!sq_busy_q) state_d = ST_AMP;
      ST_AMP: begin
        mul_a   = MulAW'(m_sel);
        mul_b   = MulBW'(out_amp_q);
        state_d = ST_BIG;
      end
      ST_BIG: state_d = (p_q == '0) ? ST_PUT : ST_XM;
      ST_XM: begin
        mul_a   = MulAW'(big_q);
        mul_b   = abs_smp(e_re_q);
        state_d = ST_XD;
      end
      ST_XD: begin
        dv_start = 1'b1;
        dv_num   = prod_q[63:0] + 64'(mag_q >> 1);
        dv_den   = mag_q;
        state_d  = ST_XW;
      end
      ST_XW: if (!dv_busy_q) state_d = ST_YM;
      ST_YM: begin
        mul_a   = MulAW'(big_q);
        mul_b   = abs_smp(e_im_q);
        state_d = ST_YD;
      end
      ST_YD: begin
        dv_start = 1'b1;
        dv_num   = prod_q[63:0] + 64'(mag_q >> 1);
        dv_den   = mag_q;
        state_d  = ST_YW;
      end
      ST_YW: if (!dv_busy_q) state_d = ST_PUT;
      ST_PUT: begin
        if (put_fire) state_d = second_q ? ST_P0 : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers: sweep counter, bin position, frame bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      bin_pos_q  <= '0;
      fc_q       <= '0;
      fw_q       <= 1'b1;
      finit_q    <= 1'b0;
      frest_q    <= 1'b0;
      second_q   <= 1'b0;
      upd_pend_q <= 1'b0;
      pend_pl_q  <= '0;
    end else begin
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (in_fire) begin
        if (pos_zero) begin
          // frame start: advance the window count, or restart it once it passes the window
          finit_q <= (fc_q == '0);
          if (fc_q > {1'b0, window_q}) begin
            frest_q <= 1'b1;
            fc_q    <= FrmCntW'(1);
            fw_q    <= 1'b0;
          end else begin
            frest_q <= 1'b0;
            fc_q    <= fc_q + 1'b1;
          end
          second_q   <= 1'b0;
          upd_pend_q <= 1'b0;
          bin_pos_q  <= last_bin_i ? '0 : AW'(1);
        end else if (pos_one) begin
          second_q   <= 1'b0;
          upd_pend_q <= 1'b0;
          if (last_eff) begin
            bin_pos_q <= '0;
          end else begin
            pend_pl_q <= '0;
            bin_pos_q <= AW'(2);
          end
        end else begin
          second_q   <= last_eff;
          upd_pend_q <= !last_eff;
          bin_pos_q  <= last_eff ? '0 : (bin_pos_q + 1'b1);
        end
      end
      if (put_fire) begin
        second_q <= 1'b0;
        if (!second_q && upd_pend_q) pend_pl_q <= p_q;
      end
    end
  end

  // held bin of the frame
  always_ff @(posedge clk_i) begin
    if (in_fire && pos_one && !last_eff) begin
      pend_re_q <= bin_re_i;
      pend_im_q <= bin_im_i;
    end else if (put_fire && !second_q && upd_pend_q) begin
      pend_re_q <= cur_re_q;
      pend_im_q <= cur_im_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_re_q <= bin_re_i;
      cur_im_q <= bin_im_i;
      if (pos_zero || pos_one) begin
        e_j_q    <= pos_zero ? '0 : AW'(1);
        e_re_q   <= bin_re_i;
        e_im_q   <= bin_im_i;
        e_pl_q   <= '0;
        e_pr_q   <= '0;
        e_last_q <= pos_zero ? last_bin_i : 1'b1;
      end else begin
        e_j_q    <= bin_pos_q - 1'b1;
        e_re_q   <= pend_re_q;
        e_im_q   <= pend_im_q;
        e_pl_q   <= pend_pl_q;
        e_last_q <= 1'b0;
      end
    end
    case (state_q)
      ST_PC1: pacc_q <= prod_q[PwrW-1:0];
      ST_PC2: e_pr_q <= pacc_q + prod_q[PwrW-1:0];
      ST_P1:  pacc_q <= prod_q[PwrW-1:0];
      ST_P2:  p_q    <= pacc_q + prod_q[PwrW-1:0];
      ST_SF:  sf_q   <= sf_sum[49:2];
      ST_SFW: sf_q   <= PwrW'(sq_root_q);
      ST_S1:  acc_q  <= prod_q[63:0];
      ST_S2:  s_q    <= mac_sum[63:16];
      ST_M: begin
        smin_q <= smin_n;
        stmp_q <= stmp_n;
        lam_q  <= rd_q.lam;
      end
      ST_N1: begin
        // update in first window, if S < Smin*delta/65536, or if power falls below noise
        cond_q <= fw_q || ({s_q, 16'd0} < prod_q[63:0]) || (lam_q > p_q);
      end
      ST_DW: if (!dv_busy_q) lam_q <= dv_q[PwrW-1:0];
      ST_L1: acc_q <= prod_q[63:0];
      ST_L2: lam_q <= (mac_sum[65:64] != 2'b00) ? '1 : mac_sum[63:16];
      ST_WB: begin
        // DC passes through
        res_re_q <= {{(OutW-SmpW){e_re_q[SmpW-1]}}, e_re_q};
        res_im_q <= {{(OutW-SmpW){e_im_q[SmpW-1]}}, e_im_q};
      end
      ST_QM: if (!sq_busy_q) mag_q <= sq_root_q;
      ST_QN: if (!sq_busy_q) nm_q <= sq_root_q;
      ST_BIG: begin
        big_q    <= prod_q[35:8];
        // zero bin carries phase zero
        res_re_q <= {4'd0, prod_q[35:8]};
        res_im_q <= '0;
      end
      ST_XW: if (!dv_busy_q) res_re_q <= sat_sm(e_re_q[SmpW-1], dv_q);
      ST_YW: if (!dv_busy_q) res_im_q <= sat_sm(e_im_q[SmpW-1], dv_q);
      ST_PUT: begin
        if (put_fire && second_q) begin
          // last bin of the frame follows its left neighbour
          e_j_q    <= e_j_q + 1'b1;
          e_re_q   <= cur_re_q;
          e_im_q   <= cur_im_q;
          e_pl_q   <= p_q;
          e_pr_q   <= '0;
          e_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_fire) begin
      out_re_q   <= res_re_q;
      out_im_q   <= res_im_q;
      out_last_q <= e_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_re_o        = out_re_q;
  assign out_im_o        = out_im_q;
  assign last_of_frame_o = out_last_q;

  // checks
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dv_busy_q && sq_busy_q))
    else $error("divider and square root busy together");

  a_dv_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> !dv_busy_q)
    else $error("divider restarted while busy");

  a_sq_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy_q)
    else $error("square root restarted while busy");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_pos_q <= LastAddr)
    else $error("bin position beyond memory depth");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!dv_busy_q && !sq_busy_q))
    else $error("word taken while an arithmetic unit is busy");

endmodule

@@ test/mcra_noise_suppressor_core_tb.sv @@
// Self-checking testbench of the MCRA noise suppressor core, with a bit-exact bin predictor.
`timescale 1ns / 1ps

module mcra_noise_suppressor_core_tb;
  import mcra_pkg::*;

  localparam int unsigned Bins      = MaxBinsDef;
  localparam int unsigned CycLimit  = 5_000_000;
  localparam int unsigned IdleAfter = 600;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam logic [63:0] Mask48 = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [OutW-1:0] re;
    logic [OutW-1:0] im;
    logic            last;
  } bin_word_t;

  // Predictor of the processed bins and store of the words still to come
  class suppressor_scoreboard;
    bit [63:0] spow [Bins];
    bit [63:0] smin_mem [Bins];
    bit [63:0] stmp_mem [Bins];
    bit [63:0] noise_mem [Bins];
    bit [63:0] frm_cnt;
    bit        first_win, restart, init_frm;
    int unsigned pos;
    logic signed [SmpW-1:0] held_re, held_im;
    bit [63:0] held_left_pwr;
    bit [63:0] a_s, a_d, a_d2, dlt, win, amp, n_only;
    bin_word_t expected_bins[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < Bins; i++) begin
        spow[i] = 0; smin_mem[i] = 0; stmp_mem[i] = 0; noise_mem[i] = 0;
      end
      frm_cnt = 0; first_win = 1; restart = 0; init_frm = 0; pos = 0;
      held_re = 0; held_im = 0; held_left_pwr = 0; errors = 0;
      a_s = AlphaSRst; a_d = AlphaDRst; a_d2 = AlphaD2Rst; dlt = DeltaRst;
      win = WindowRst; amp = OutAmpRst; n_only = NoiseOnlyRst;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_ALPHA_S:    a_s = d;
        CFG_ALPHA_D:    a_d = d;
        CFG_ALPHA_D2:   a_d2 = d;
        CFG_DELTA:      dlt = d;
        CFG_WINDOW:     win = d;
        CFG_OUT_AMP:    amp = d[11:0];
        CFG_NOISE_ONLY: n_only = d[0];
        default: ;
      endcase
    endfunction

    function bit [63:0] magn(logic signed [SmpW-1:0] v);
      longint x;
      x = v;
      return (x < 0) ? -x : x;
    endfunction

    function bit [63:0] pwr(logic signed [SmpW-1:0] re, logic signed [SmpW-1:0] im);
      return magn(re) * magn(re) + magn(im) * magn(im);
    endfunction

    function bit [63:0] root(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [OutW-1:0] sat32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[OutW-1:0];
    endfunction

    function logic [OutW-1:0] scale(logic signed [SmpW-1:0] x, bit [63:0] m, bit [63:0] mag);
      bit [63:0] q;
      q = (magn(x) * m + mag / 2) / mag;
      return sat32((x < 0) ? -longint'(q) : longint'(q));
    endfunction

    function void frame_begin();
      init_frm = (frm_cnt == 0);
      if (frm_cnt > win) begin
        restart = 1; frm_cnt = 1; first_win = 0;
      end else begin
        restart = 0; frm_cnt++;
      end
    endfunction

    // Update the state of bin j and predict its output word
    function bin_word_t predict_bin(int unsigned j, logic signed [SmpW-1:0] re,
                                    logic signed [SmpW-1:0] im, bit [63:0] pl,
                                    bit [63:0] pr, bit last);
      bit [63:0] p, sf, s, mn, tm, lam, n, a, b, mag, nm, m, big;
      bin_word_t w;
      if (j >= Bins) j = Bins - 1;
      p = pwr(re, im);
      sf = (j == 0) ? root(p) : (pl + 2 * p + pr) >> 2;
      s = (a_s * spow[j] + (65536 - a_s) * sf + 32768) >> 16;
      mn = smin_mem[j];
      tm = stmp_mem[j];
      if (init_frm) begin
        mn = s; tm = s;
      end
      if (restart) begin
        mn = (tm < s) ? tm : s; tm = s;
      end else begin
        mn = (mn < s) ? mn : s; tm = (tm < s) ? tm : s;
      end
      lam = noise_mem[j];
      n = frm_cnt;
      if (first_win || (s << 16) < mn * dlt || lam > p) begin
        if (first_win && a_d * n < 65536 && n != 0) begin
          lam = (lam + (n - 1) * p) / n;
        end else begin
          a = a_d2 * lam;
          b = (65536 - a_d) * p;
          lam = (a >> 16) + (b >> 16) + (((a & 64'hFFFF) + (b & 64'hFFFF) + 32768) >> 16);
          if (lam > Mask48) lam = Mask48;
        end
      end
      spow[j] = s; smin_mem[j] = mn; stmp_mem[j] = tm; noise_mem[j] = lam;
      if (j == 0) begin
        w.re = sat32(longint'(re));
        w.im = sat32(longint'(im));
      end else begin
        mag = root(p);
        nm = root(lam);
        m = n_only ? nm : ((mag > nm) ? mag - nm : 0);
        big = (m * amp) >> 8;
        if (p == 0) begin
          w.re = sat32(longint'(big));
          w.im = '0;
        end else begin
          w.re = scale(re, big, mag);
          w.im = scale(im, big, mag);
        end
      end
      w.last = last;
      return w;
    endfunction

    // An accepted input word: queue the words it releases
    function void note_bin(logic signed [SmpW-1:0] re, logic signed [SmpW-1:0] im, bit last);
      int unsigned p;
      bit [63:0] ph, pc;
      p = pos;
      if (p == 0) begin
        frame_begin();
        expected_bins.push_back(predict_bin(0, re, im, 0, 0, last));
        pos = last ? 0 : 1;
        return;
      end
      if (p >= Bins - 1) begin
        p = Bins - 1; last = 1;
      end
      if (p == 1) begin
        if (last) begin
          expected_bins.push_back(predict_bin(1, re, im, 0, 0, 1'b1));
          pos = 0;
          return;
        end
        held_re = re; held_im = im; held_left_pwr = 0; pos = 2;
        return;
      end
      ph = pwr(held_re, held_im);
      pc = pwr(re, im);
      expected_bins.push_back(predict_bin(p - 1, held_re, held_im, held_left_pwr, pc, 1'b0));
      if (last) begin
        expected_bins.push_back(predict_bin(p, re, im, ph, 0, 1'b1));
        pos = 0;
        return;
      end
      held_re = re; held_im = im; held_left_pwr = ph; pos = p + 1;
    endfunction

    function void check_bin(bin_word_t got);
      bin_word_t want;
      if (expected_bins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word re=%0d im=%0d last=%0b",
                                   $signed(got.re), $signed(got.im), got.last);
        return;
      end
      want = expected_bins.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                   $signed(want.re), $signed(want.im), want.last,
                   $signed(got.re), $signed(got.im), got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SmpW-1:0] bin_re_i = '0;
  logic signed [SmpW-1:0] bin_im_i = '0;
  logic last_bin_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OutW-1:0] out_re_o;
  logic signed [OutW-1:0] out_im_o;
  logic last_of_frame_o;

  suppressor_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit steady = 0;

  mcra_noise_suppressor_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .bin_re_i, .bin_im_i, .last_bin_i,
    .out_valid_o, .out_ready_i, .out_re_o, .out_im_o, .last_of_frame_o
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("FAIL mcra_noise_suppressor_core");
      $finish;
    end
  end

  // Receiver back-pressure: mostly ready, short stalls, a few long ones
  always @(negedge clk_i) begin
    if (steady) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) out_ready_i <= 1'b1;
      else begin
        out_ready_i <= 1'b0;
        stall_left <= (r < 95) ? $urandom_range(3) : $urandom_range(150, 20);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_bin('{re: out_re_o, im: out_im_o, last: last_of_frame_o});
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(4, 1);
    return $urandom_range(200, 20);
  endfunction

  function automatic logic signed [SmpW-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1:       return r[0] ? 24'sh7FFFFF : 24'sh800000;
      2, 3:    return $signed(24'(r[8:0])) - 24'sd256;
      default: return r[SmpW-1:0];
    endcase
  endfunction

  task automatic send_bin(logic signed [SmpW-1:0] re, logic signed [SmpW-1:0] im, bit last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_re_i <= re;
    bin_im_i <= im;
    last_bin_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_bin(re, im, last);
  endtask

  task automatic send_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_bin(pick_sample(), pick_sample(), i == len - 1);
  endtask

  // Let every expected word arrive, then let a word that gives no result finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_bins.size() != 0) @(posedge clk_i);
    repeat (IdleAfter) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] as, logic [15:0] ad, logic [15:0] ad2,
                           logic [15:0] dl, logic [15:0] wc, logic [15:0] am, logic [15:0] no);
    write_reg(CFG_ALPHA_S, as);
    write_reg(CFG_ALPHA_D, ad);
    write_reg(CFG_ALPHA_D2, ad2);
    write_reg(CFG_DELTA, dl);
    write_reg(CFG_WINDOW, wc);
    write_reg(CFG_OUT_AMP, am);
    write_reg(CFG_NOISE_ONLY, no);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, unused index, extremes, short frames
    write_all(AlphaSRst, AlphaDRst, AlphaD2Rst, DeltaRst, WindowRst, 16'h0200, 16'h0000);
    write_reg(CfgIdxUnused, 16'hFFFF);
    send_bin(24'sh7FFFFF, 24'sh800000, 1'b1);       // single-bin frame
    send_bin(24'sd5, -24'sd3, 1'b0);
    send_bin(24'sh800000, 24'sh7FFFFF, 1'b1);       // two-bin frame
    send_bin(24'sd100, 24'sd0, 1'b0);
    send_bin(24'sd0, 24'sd0, 1'b0);                 // zero bin
    send_bin(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_bin(24'sh800000, 24'sh800000, 1'b0);
    send_bin(-24'sd1, 24'sd1, 1'b1);
    drain();

    // Noise only, full gain (upper data bits dropped), quick restarts
    write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFF);
    for (int f = 0; f < 4; f++) send_frame(3 + f);
    drain();

    // Restart every frame, noise growth towards saturation, zero gain then unity
    write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int f = 0; f < 3; f++) begin
      send_bin(24'sh7FFFFF, 24'sh800000, 1'b0);
      send_bin(24'sh800000, 24'sh7FFFFF, 1'b0);
      send_bin(24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
    end
    drain();
    write_reg(CFG_OUT_AMP, 16'd256);
    send_frame(4);
    drain();

    // Random phases
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned sent;
      write_all(16'($urandom_range(3) == 0 ? $urandom : $urandom_range(65535, 55000)),
                16'($urandom_range(3) == 0 ? $urandom : $urandom_range(65535, 55000)),
                16'($urandom_range(3) == 0 ? $urandom : $urandom_range(65535, 55000)),
                16'($urandom_range(1) ? $urandom_range(200) : $urandom),
                16'($urandom_range(6)), 16'($urandom_range(4095)), 16'($urandom_range(1)));
      steady = (ph == 2);
      sent = 0;
      while (sent < 95) begin
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
        send_frame(len);
        sent += len;
      end
      drain();
    end
    steady = 0;

    if (sb.errors == 0 && sb.expected_bins.size() == 0) begin
      $display("PASS mcra_noise_suppressor_core");
    end else begin
      $display("FAIL mcra_noise_suppressor_core");
    end
    $finish;
  end

endmodule
